// ===== rtl/rdes_pkg.sv =====
// Shared constants, register codes and helper functions of the random daily event scheduler.
// Used by rdes_mod and the top module; depends on nothing else.
`default_nettype none

package rdes_pkg;

    // Default number of schedule slots.
    localparam int MAX_EVENTS_DEF = 9;

    // Field widths.
    localparam int MIN_W   = 11;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 4;
    localparam int CODE_W  = 8;
    localparam int RND_W   = 32;
    localparam int TOT_W   = 32;
    localparam int IDX_W   = 8;

    // Stream word widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_EVENTS = 3'd0;
    localparam logic [2:0] REG_WCODE  = 3'd1;
    localparam logic [2:0] REG_WSTART = 3'd2;
    localparam logic [2:0] REG_WEND   = 3'd3;
    localparam logic [2:0] REG_SEED   = 3'd4;

    // Operation codes carried in tuser.
    localparam logic OP_CHECK   = 1'b0;
    localparam logic OP_DELIVER = 1'b1;

    // Galois LFSR feedback mask, shifting right.
    localparam logic [RND_W-1:0] LFSR_MASK = 32'h8020_0003;

    // One step of the random generator.
    function automatic logic [RND_W-1:0] lfsr_step(input logic [RND_W-1:0] s);
        logic [RND_W-1:0] shifted;
        shifted = s >> 1;
        return s[0] ? (shifted ^ LFSR_MASK) : shifted;
    endfunction

    // A zero seed would lock the generator up, so it loads as one.
    function automatic logic [RND_W-1:0] seed_value(input logic [RND_W-1:0] s);
        return (s == '0) ? RND_W'(1) : s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rdes_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Holds the sorted event times; depends on nothing else.
`default_nettype none

module rdes_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 9
) (
    input  wire                                    aclk,
    input  wire                                    we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                       wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/rdes_mod.sv =====
// Bit-serial remainder unit: 32-bit random value modulo an 11-bit window span.
// Depends on rdes_pkg for the widths.
`default_nettype none

module rdes_mod (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  [rdes_pkg::RND_W-1:0]   dividend,
    input  wire  [rdes_pkg::MIN_W-1:0]   divisor,
    output logic                         done,
    output logic [rdes_pkg::MIN_W-1:0]   remainder
);

    localparam int BIT_CNT_W = $clog2(rdes_pkg::RND_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [BIT_CNT_W-1:0]         cnt_reg, cnt_next;
    logic [rdes_pkg::RND_W-1:0]   quo_reg, quo_next;
    logic [rdes_pkg::MIN_W-1:0]   rem_reg, rem_next;
    logic [rdes_pkg::MIN_W:0]     trial;
    logic [rdes_pkg::MIN_W:0]     div_ext;

    assign div_ext = {1'b0, divisor};
    assign trial   = {rem_reg, quo_reg[rdes_pkg::RND_W-1]};

    // One restoring step per cycle, most significant dividend bit first.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next = quo_reg << 1;
            if (trial >= div_ext) begin
                rem_next = rdes_pkg::MIN_W'(trial - div_ext);
            end else begin
                rem_next = trial[rdes_pkg::MIN_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_W'(rdes_pkg::RND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/random_daily_event_scheduler.sv =====
// Random daily event scheduler: a check word reports whether the next of up to MAX_EVENTS
// random daily times has been reached; a deliver word advances the schedule and counts it.
// A check on the first valid time, on a new day, or after the event count or window code
// changed redraws the schedule: for each event the LFSR steps once, a bit-serial remainder
// unit reduces the value modulo the window span, and the time is insertion-sorted into a
// small RAM, one compare and move at a time. Handing a result over waits while the output
// register is still full. The input is not ready while a word is in work; one result may
// wait in the output register while the next word is taken. No clearing pass follows reset.
// Depends on rdes_pkg, rdes_ram and rdes_mod.
`default_nettype none

module random_daily_event_scheduler #(
    parameter int MAX_EVENTS = rdes_pkg::MAX_EVENTS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Input stream.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [rdes_pkg::S_TDATA_W-1:0]   s_tdata,   // day_of_month[4:0], minute_of_day[15:5]
    input  wire  [rdes_pkg::S_TUSER_W-1:0]   s_tuser,   // operation[0], time_valid[1]
    // Result stream.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [rdes_pkg::M_TDATA_W-1:0]   m_tdata,   // event_due[0], delivered_total[32:1]
    // Configuration port.
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [rdes_pkg::PADDR_W-1:0]     paddr,
    input  wire  [rdes_pkg::PDATA_W-1:0]     pwdata,
    output logic [rdes_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam logic [4:0] MAX5 = 5'(MAX_EVENTS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_STEP     = 3'd1;
    localparam logic [2:0] ST_MODW     = 3'd2;
    localparam logic [2:0] ST_INS_RD   = 3'd3;
    localparam logic [2:0] ST_INS_CMP  = 3'd4;
    localparam logic [2:0] ST_LOOK     = 3'd5;
    localparam logic [2:0] ST_LOOK_CMP = 3'd6;
    localparam logic [2:0] ST_FIN      = 3'd7;

    logic [2:0]                     state_reg, state_next;
    logic [rdes_pkg::CNT_W-1:0]     epd_reg, epd_next;
    logic [rdes_pkg::CODE_W-1:0]    wcode_reg, wcode_next;
    logic [rdes_pkg::MIN_W-1:0]     wstart_reg, wstart_next;
    logic [rdes_pkg::MIN_W-1:0]     wend_reg, wend_next;
    logic [rdes_pkg::RND_W-1:0]     seed_reg, seed_next;
    logic                           armed_reg, armed_next;
    logic [rdes_pkg::CNT_W-1:0]     scnt_reg, scnt_next;
    logic [rdes_pkg::CODE_W-1:0]    swcode_reg, swcode_next;
    logic [rdes_pkg::DAY_W-1:0]     sday_reg, sday_next;
    logic [rdes_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [rdes_pkg::RND_W-1:0]     rnd_reg, rnd_next;
    logic [rdes_pkg::TOT_W-1:0]     total_reg, total_next;
    logic [rdes_pkg::MIN_W-1:0]     minute_reg, minute_next;
    logic [CW-1:0]                  i_reg, i_next;
    logic [CW-1:0]                  j_reg, j_next;
    logic [CW-1:0]                  n_reg, n_next;
    logic [rdes_pkg::MIN_W-1:0]     val_reg, val_next;
    logic                           due_reg, due_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [rdes_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Input word fields.
    logic                           in_op;
    logic                           in_tvalid;
    logic [rdes_pkg::DAY_W-1:0]     in_day;
    logic [rdes_pkg::MIN_W-1:0]     in_minute;

    // Configuration write decode.
    logic                           cfg_wr;
    logic [2:0]                     cfg_idx;

    // Derived counts and helpers.
    logic [4:0]                     eff_cfg5, eff_saved5;
    logic [CW-1:0]                  eff_cfg, eff_saved;
    logic [CW-1:0]                  i_inc, j_dec;
    logic [rdes_pkg::RND_W-1:0]     lfsr_val;
    logic [rdes_pkg::MIN_W:0]       time_sum;
    logic                           need_redraw;

    // Memory and remainder unit connections.
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    logic [rdes_pkg::MIN_W-1:0]     ram_wdata, ram_rdata;
    logic                           mod_start, mod_done;
    logic [rdes_pkg::MIN_W-1:0]     mod_rem;

    assign in_op     = s_tuser[0];
    assign in_tvalid = s_tuser[1];
    assign in_day    = s_tdata[4:0];
    assign in_minute = s_tdata[15:5];

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    // Event counts above the slot count are clamped.
    assign eff_cfg5   = ({1'b0, epd_reg} > MAX5) ? MAX5 : {1'b0, epd_reg};
    assign eff_saved5 = ({1'b0, scnt_reg} > MAX5) ? MAX5 : {1'b0, scnt_reg};
    assign eff_cfg    = eff_cfg5[CW-1:0];
    assign eff_saved  = eff_saved5[CW-1:0];

    assign i_inc    = i_reg + 1'b1;
    assign j_dec    = j_reg - 1'b1;
    assign lfsr_val = rdes_pkg::lfsr_step(rnd_reg);
    assign time_sum = {1'b0, wstart_reg} + {1'b0, mod_rem};

    assign need_redraw = !armed_reg || (epd_reg != scnt_reg) ||
                         (wcode_reg != swcode_reg) || (in_day != sday_reg);

    // Sequencer and register file.
    always_comb begin
        state_next    = state_reg;
        epd_next      = epd_reg;
        wcode_next    = wcode_reg;
        wstart_next   = wstart_reg;
        wend_next     = wend_reg;
        seed_next     = seed_reg;
        armed_next    = armed_reg;
        scnt_next     = scnt_reg;
        swcode_next   = swcode_reg;
        sday_next     = sday_reg;
        idx_next      = idx_reg;
        rnd_next      = rnd_reg;
        total_next    = total_reg;
        minute_next   = minute_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        val_next      = val_reg;
        due_next      = due_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = j_reg[AW-1:0];
        ram_wdata     = val_reg;
        ram_raddr     = j_dec[AW-1:0];
        mod_start     = 1'b0;

        // Configuration writes must arrive only while the block is idle; the block does not enforce this.
        if (cfg_wr) begin
            case (cfg_idx)
                rdes_pkg::REG_EVENTS: epd_next    = pwdata[rdes_pkg::CNT_W-1:0];
                rdes_pkg::REG_WCODE:  wcode_next  = pwdata[rdes_pkg::CODE_W-1:0];
                rdes_pkg::REG_WSTART: wstart_next = pwdata[rdes_pkg::MIN_W-1:0];
                rdes_pkg::REG_WEND:   wend_next   = pwdata[rdes_pkg::MIN_W-1:0];
                rdes_pkg::REG_SEED: begin
                    seed_next = pwdata;
                    rnd_next  = rdes_pkg::seed_value(pwdata);
                end
                default: ;
            endcase
        end

        // The result register empties when the sink takes the word.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    due_next = 1'b0;
                    if (in_op == rdes_pkg::OP_DELIVER) begin
                        if (idx_reg != {rdes_pkg::IDX_W{1'b1}}) begin
                            idx_next = idx_reg + 1'b1;
                        end
                        total_next = total_reg + 1'b1;
                        state_next = ST_FIN;
                    end else if (!in_tvalid) begin
                        state_next = ST_FIN;
                    end else begin
                        minute_next = in_minute;
                        state_next  = ST_LOOK;
                        if (need_redraw) begin
                            armed_next  = 1'b1;
                            scnt_next   = epd_reg;
                            swcode_next = wcode_reg;
                            sday_next   = in_day;
                            n_next      = eff_cfg;
                            if ((eff_cfg == '0) || (wend_reg <= wstart_reg)) begin
                                // Disabled schedule: nothing is ever pending.
                                idx_next = rdes_pkg::IDX_W'(eff_cfg);
                            end else begin
                                idx_next   = '0;
                                i_next     = '0;
                                state_next = ST_STEP;
                            end
                        end
                    end
                end
            end

            // Step the generator and start the reduction of the new value.
            ST_STEP: begin
                rnd_next   = lfsr_val;
                mod_start  = 1'b1;
                state_next = ST_MODW;
            end

            ST_MODW: begin
                if (mod_done) begin
                    val_next   = time_sum[rdes_pkg::MIN_W-1:0];
                    j_next     = i_reg;
                    state_next = ST_INS_RD;
                end
            end

            // Insertion: fetch the entry below the hole, or drop the time at the bottom.
            ST_INS_RD: begin
                if (j_reg == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    i_next    = i_inc;
                    state_next = (i_inc == n_reg) ? ST_LOOK : ST_STEP;
                end else begin
                    state_next = ST_INS_CMP;
                end
            end

            // Move a larger entry up one slot, or place the new time in the hole.
            ST_INS_CMP: begin
                ram_we = 1'b1;
                if (ram_rdata > val_reg) begin
                    ram_wdata  = ram_rdata;
                    j_next     = j_dec;
                    state_next = ST_INS_RD;
                end else begin
                    i_next     = i_inc;
                    state_next = (i_inc == n_reg) ? ST_LOOK : ST_STEP;
                end
            end

            // Fetch the next pending time, if there is one.
            ST_LOOK: begin
                ram_raddr = idx_reg[AW-1:0];
                if (idx_reg < rdes_pkg::IDX_W'(eff_saved)) begin
                    state_next = ST_LOOK_CMP;
                end else begin
                    due_next   = 1'b0;
                    state_next = ST_FIN;
                end
            end

            ST_LOOK_CMP: begin
                due_next   = (minute_reg >= ram_rdata);
                state_next = ST_FIN;
            end

            // Hand the result to the output register once it is free.
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_data_next   = {7'd0, total_reg, due_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            epd_reg      <= '0;
            wcode_reg    <= '0;
            wstart_reg   <= '0;
            wend_reg     <= '0;
            seed_reg     <= rdes_pkg::RND_W'(1);
            armed_reg    <= 1'b0;
            scnt_reg     <= '0;
            swcode_reg   <= '0;
            sday_reg     <= '0;
            idx_reg      <= '0;
            rnd_reg      <= rdes_pkg::RND_W'(1);
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            epd_reg      <= epd_next;
            wcode_reg    <= wcode_next;
            wstart_reg   <= wstart_next;
            wend_reg     <= wend_next;
            seed_reg     <= seed_next;
            armed_reg    <= armed_next;
            scnt_reg     <= scnt_next;
            swcode_reg   <= swcode_next;
            sday_reg     <= sday_next;
            idx_reg      <= idx_next;
            rnd_reg      <= rnd_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        minute_reg <= minute_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        val_reg    <= val_next;
        due_reg    <= due_next;
        m_data_reg <= m_data_next;
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            rdes_pkg::REG_EVENTS: prdata = rdes_pkg::PDATA_W'(epd_reg);
            rdes_pkg::REG_WCODE:  prdata = rdes_pkg::PDATA_W'(wcode_reg);
            rdes_pkg::REG_WSTART: prdata = rdes_pkg::PDATA_W'(wstart_reg);
            rdes_pkg::REG_WEND:   prdata = rdes_pkg::PDATA_W'(wend_reg);
            rdes_pkg::REG_SEED:   prdata = seed_reg;
            default:              prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // Sorted event times.
    rdes_ram #(
        .WIDTH (rdes_pkg::MIN_W),
        .DEPTH (MAX_EVENTS)
    ) u_times (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared remainder unit: random value modulo the window span.
    rdes_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (lfsr_val),
        .divisor   (rdes_pkg::MIN_W'(wend_reg - wstart_reg)),
        .done      (mod_done),
        .remainder (mod_rem)
    );

endmodule

`default_nettype wire
